>>> rtl/core/sfcd_pkg.sv
// ----------------------------------------------------------------------------
// sfcd_pkg: shared types, constants and functions
// Frame layout, CRC-8 step function and the record that passes from the
// byte assembler to the scaling back end.
// ----------------------------------------------------------------------------
package sfcd_pkg;

   localparam int BYTE_W    = 8;
   localparam int WORD_W    = 16;
   localparam int POS_W     = 4;
   localparam int TEMP_W    = 15;
   localparam int HUMID_W   = 14;
   localparam int RSP_DATA_W = 48;

   // Byte positions inside the nine-byte frame.
   localparam logic [POS_W-1:0] POS_CO2_HI   = 4'd0;
   localparam logic [POS_W-1:0] POS_CO2_LO   = 4'd1;
   localparam logic [POS_W-1:0] POS_CO2_CRC  = 4'd2;
   localparam logic [POS_W-1:0] POS_TEMP_HI  = 4'd3;
   localparam logic [POS_W-1:0] POS_TEMP_LO  = 4'd4;
   localparam logic [POS_W-1:0] POS_TEMP_CRC = 4'd5;
   localparam logic [POS_W-1:0] POS_HUM_HI   = 4'd6;
   localparam logic [POS_W-1:0] POS_HUM_LO   = 4'd7;
   localparam logic [POS_W-1:0] POS_HUM_CRC  = 4'd8;
   localparam logic [POS_W-1:0] POS_LAST     = POS_HUM_CRC;

   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

   // Scaling: hundredths of the physical unit over a 16-bit raw word.
   localparam logic [WORD_W-1:0] TEMP_SPAN   = 16'd17500;
   localparam logic [WORD_W-1:0] HUMID_SPAN  = 16'd10000;
   localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd4500;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_IDX_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef struct packed {
      logic [WORD_W-1:0] co2_word;
      logic [WORD_W-1:0] temp_word;
      logic [WORD_W-1:0] humid_word;
      logic              crc_failed;
   } frame_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // One byte through the MSB-first CRC-8 shift register.
   function automatic logic [BYTE_W-1:0] crc_update(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/core/sfcd_front.sv
// ----------------------------------------------------------------------------
// sfcd_front: frame byte assembler
// Tracks the byte position, runs the CRC-8 per word, assembles the three
// words and pushes one frame record after the last byte.
// ----------------------------------------------------------------------------
module sfcd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sfcd_pkg::BYTE_W-1:0]   rx_byte,
   input  logic                          frame_start,
   input  sfcd_pkg::queue_stat_type      queue_stat,
   output logic                          push_valid,
   output sfcd_pkg::frame_rec_type       push_rec
);
   import sfcd_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] crc_ff, crc_in;
   logic              failed_ff, failed_in;
   logic [WORD_W-1:0] co2_ff, temp_ff, humid_ff;

   logic              accept;
   logic [POS_W-1:0]  pos_eff;
   logic              fail_base;
   logic              mismatch;

   assign req_tready = !queue_stat.full;
   assign accept     = req_tvalid && req_tready;

   // A frame start, or a position past the end, counts as the first byte.
   assign pos_eff   = (frame_start || (pos_ff > POS_LAST)) ? POS_CO2_HI : pos_ff;
   assign fail_base = frame_start ? 1'b0 : failed_ff;
   assign mismatch  = (crc_ff != rx_byte);

   always_comb begin
      pos_in    = (pos_eff == POS_LAST) ? POS_CO2_HI : pos_eff + 4'd1;
      crc_in    = crc_ff;
      failed_in = fail_base;
      case (pos_eff)
         POS_CO2_HI, POS_TEMP_HI, POS_HUM_HI: begin
            crc_in = crc_update(CRC_INIT, rx_byte);
         end
         POS_CO2_LO, POS_TEMP_LO, POS_HUM_LO: begin
            crc_in = crc_update(crc_ff, rx_byte);
         end
         POS_CO2_CRC, POS_TEMP_CRC: begin
            crc_in    = CRC_INIT;
            failed_in = fail_base | mismatch;
         end
         POS_HUM_CRC: begin
            crc_in    = CRC_INIT;
            failed_in = 1'b0;
         end
         default: begin
            crc_in = crc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_CO2_HI;
         crc_ff    <= CRC_INIT;
         failed_ff <= 1'b0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         failed_ff <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         case (pos_eff)
            POS_CO2_HI:  co2_ff[15:8]   <= rx_byte;
            POS_CO2_LO:  co2_ff[7:0]    <= rx_byte;
            POS_TEMP_HI: temp_ff[15:8]  <= rx_byte;
            POS_TEMP_LO: temp_ff[7:0]   <= rx_byte;
            POS_HUM_HI:  humid_ff[15:8] <= rx_byte;
            POS_HUM_LO:  humid_ff[7:0]  <= rx_byte;
            default: begin
            end
         endcase
      end
   end

   assign push_valid          = accept && (pos_eff == POS_LAST);
   assign push_rec.co2_word   = co2_ff;
   assign push_rec.temp_word  = temp_ff;
   assign push_rec.humid_word = humid_ff;
   assign push_rec.crc_failed = fail_base | mismatch;

endmodule

>>> rtl/core/sfcd_queue.sv
// ----------------------------------------------------------------------------
// sfcd_queue: frame record queue
// Two-entry register queue between the byte assembler and the back end.
// ----------------------------------------------------------------------------
module sfcd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  sfcd_pkg::frame_rec_type   push_rec,
   input  logic                      pop,
   output sfcd_pkg::frame_rec_type   pop_rec,
   output sfcd_pkg::queue_stat_type  queue_stat
);
   import sfcd_pkg::*;

   frame_rec_type           entry_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_push, do_pop;

   assign queue_stat.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign queue_stat.empty = (count_ff == '0);

   assign do_push = push_valid && !queue_stat.full;
   assign do_pop  = pop && !queue_stat.empty;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   assign pop_rec = entry_ff[rd_ptr_ff];

endmodule

>>> rtl/core/sfcd_back.sv
// ----------------------------------------------------------------------------
// sfcd_back: measurement scaling back end
// Multiplies the raw temperature and humidity words by their spans, then
// takes the upper bits, applies the temperature offset and holds the result
// in the output register.
// ----------------------------------------------------------------------------
module sfcd_back (
   input  logic                           clock,
   input  logic                           reset,
   input  sfcd_pkg::queue_stat_type       queue_stat,
   input  sfcd_pkg::frame_rec_type        pop_rec,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sfcd_pkg::WORD_W-1:0]    co2_ppm,
   output logic [sfcd_pkg::TEMP_W-1:0]    temp_centi,
   output logic [sfcd_pkg::HUMID_W-1:0]   humid_centi,
   output logic                           frame_status
);
   import sfcd_pkg::*;

   localparam int PROD_W = 2 * WORD_W;

   logic                a_valid_ff;
   logic [PROD_W-1:0]   a_temp_prod_ff, a_humid_prod_ff;
   logic [WORD_W-1:0]   a_co2_ff;
   logic                a_failed_ff;

   logic                out_valid_ff;
   logic [WORD_W-1:0]   co2_ff;
   logic [TEMP_W-1:0]   temp_ff, temp_in;
   logic [HUMID_W-1:0]  humid_ff, humid_in;
   logic                status_ff;

   logic                out_ready, a_ready;

   assign out_ready = !out_valid_ff || rsp_tready;
   assign a_ready   = !a_valid_ff || out_ready;
   assign pop       = !queue_stat.empty && a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         a_temp_prod_ff  <= PROD_W'(pop_rec.temp_word) * PROD_W'(TEMP_SPAN);
         a_humid_prod_ff <= PROD_W'(pop_rec.humid_word) * PROD_W'(HUMID_SPAN);
         a_co2_ff        <= pop_rec.co2_word;
         a_failed_ff     <= pop_rec.crc_failed;
      end
   end

   // Floor of the product over 65536; the subtraction wraps in two's complement.
   assign temp_in  = a_temp_prod_ff[WORD_W +: TEMP_W] - TEMP_OFFSET;
   assign humid_in = a_humid_prod_ff[WORD_W +: HUMID_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && a_valid_ff) begin
         co2_ff    <= a_co2_ff;
         temp_ff   <= temp_in;
         humid_ff  <= humid_in;
         status_ff <= a_failed_ff;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign co2_ppm      = co2_ff;
   assign temp_centi   = temp_ff;
   assign humid_centi  = humid_ff;
   assign frame_status = status_ff;

endmodule

>>> rtl/core/sensor_frame_crc_decoder_unit.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_decoder_unit: sensor measurement frame decoder
// Decodes a nine-byte CO2 / temperature / humidity frame with CRC-8 checks.
// ----------------------------------------------------------------------------
// The block takes one frame byte per item on the req channel, in wire order,
// and accepts a byte in every clock cycle as long as its two-entry frame
// queue has room. A frame holds three words (CO2, raw temperature, raw
// humidity), each two bytes most significant first plus a CRC-8 byte
// (polynomial 0x31, initial value 0xFF). A set req_tuser marks the first byte
// of a frame and drops any partial frame; without it, frames simply follow
// one another. After the ninth byte one result item appears on the rsp
// channel, passing the queue stage, one multiplier stage and the output
// register: the CO2 word, temperature in signed hundredths of a degree
// Celsius (floor(17500*raw/65536) - 4500), humidity in hundredths of a
// percent (floor(10000*raw/65536)), and in rsp_tuser a flag that is set
// when any of the three CRC bytes did not match. Results keep flowing
// while the output waits, until the queue fills; then req_tready drops.
// ----------------------------------------------------------------------------
module sensor_frame_crc_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] co2_ppm, [30:16] temp_centi,
                                    // [44:31] humid_centi, [47:45] zero
   output logic        rsp_tuser    // [0] frame_status
);
   import sfcd_pkg::*;

   queue_stat_type       queue_stat;
   frame_rec_type        push_rec, pop_rec;
   logic                 push_valid, pop;
   logic [WORD_W-1:0]    co2_ppm;
   logic [TEMP_W-1:0]    temp_centi;
   logic [HUMID_W-1:0]   humid_centi;
   logic                 frame_status;

   // Front end: position tracking, CRC and word assembly.
   sfcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rx_byte     (req_tdata),
      .frame_start (req_tuser),
      .queue_stat  (queue_stat),
      .push_valid  (push_valid),
      .push_rec    (push_rec)
   );

   // The queue lets the front keep taking bytes while the result side stalls.
   sfcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .pop        (pop),
      .pop_rec    (pop_rec),
      .queue_stat (queue_stat)
   );

   // Back end: fixed-point scaling and the output register.
   sfcd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_stat   (queue_stat),
      .pop_rec      (pop_rec),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .co2_ppm      (co2_ppm),
      .temp_centi   (temp_centi),
      .humid_centi  (humid_centi),
      .frame_status (frame_status)
   );

   assign rsp_tdata = {3'b000, humid_centi, temp_centi, co2_ppm};
   assign rsp_tuser = frame_status;

endmodule

>>> rtl/core/sfcd_checker.sv
// ----------------------------------------------------------------------------
// sfcd_checker: port-level checks for the frame decoder
// Watches the top-level ports and flags results that break the output rules.
// ----------------------------------------------------------------------------
module sfcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // No result is pending right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // A stalled result holds its data.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Temperature stays within -45.00 to 129.99 degrees.
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[30:16]) >= -15'sd4500) &&
                     ($signed(rsp_tdata[30:16]) <= 15'sd12999))
      else $error("temperature out of range");

   // Humidity stays below 100.00 percent and the padding bits are zero.
   a_humid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[44:31] <= 14'd9999) && (rsp_tdata[47:45] == 3'b000))
      else $error("humidity out of range or padding set");

endmodule

bind sensor_frame_crc_decoder_unit sfcd_checker u_sfcd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
